[rtl/sdw_pkg.sv]
package sdw_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef enum logic {
        MODE_SLEEP = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_WOKEN  = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_FIN  = 2'd2
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [7:0]  thread_id;
        logic [15:0] delay;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] woken_id;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] deadline;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;   // write new entry at the fill position
        logic step;   // rotate the occupied part of the row by one
        logic keep;   // head entry survives the step and moves to the tail
    } t_cell_ctrl;

endpackage

[rtl/sdw_cell.sv]
module sdw_cell
    import sdw_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                               i_clk,
    input  t_cell_ctrl                         i_ctrl,
    input  logic [$clog2(CAPACITY + 1) - 1:0]  i_count,
    input  t_entry                             i_new,
    input  t_entry                             i_right,
    input  t_entry                             i_head,
    output t_entry                             o_entry
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] POS_HERE = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.load && (i_count == POS_HERE)) begin
            n_entry = i_new;
        end else if (i_ctrl.step) begin
            if (POS_NEXT < i_count) begin
                n_entry = i_right;
            end else if ((POS_NEXT == i_count) && i_ctrl.keep) begin
                n_entry = i_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[rtl/sleep_deadline_wakeup_core.sv]
// Sleep table driven by timer ticks. A sleep word (mode 0) stores thread_id with
// deadline = tick count + delay (saturating at 2^32-1) and returns one result,
// status accept, or status full when CAPACITY entries are held; that result
// appears in the cycle after acceptance and busy stays low. A tick word (mode 1)
// advances the saturating tick count, then busy rises until the N entries held at
// the tick are swept and the last result is issued; they sit in a row of cells,
// oldest in cell 0, and the occupied part of the row rotates one place per cycle,
// so the head entry is compared with the tick count once per cycle. Expired
// entries drop out and come out as woken results in insertion order, the
// survivors return to the tail in their old order. A woken result is held back
// until its last flag is known; a tick that wakes nothing gives one none
// result. At most one result per cycle, marked by o_strobe for exactly one cycle;
// there is no backpressure, so the receiver must take every result as it comes.
module sleep_deadline_wakeup_core
    import sdw_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_strobe,
    output t_out_word o_word
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(CAPACITY);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

    // control state
    t_state        r_state, n_state;
    logic [31:0]   r_tick, n_tick;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_steps, n_steps;    // head checks left in this sweep
    logic          r_pend_vld, n_pend_vld;
    logic [7:0]    r_pend_id, n_pend_id; // woken id held back until last is known
    logic          r_strobe, n_strobe;
    t_out_word     r_res, n_res;

    t_cell_ctrl    w_ctrl;
    t_entry        w_new;
    t_entry        w_entry [CAPACITY];
    logic [32:0]   w_sum;
    logic          w_accept;
    logic          w_expired;

    assign w_accept  = start && (r_state == S_IDLE);
    assign w_sum     = {1'b0, r_tick} + 33'(i_word.delay);
    assign w_new.id       = i_word.thread_id;
    assign w_new.deadline = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_expired = (w_entry[0].deadline <= r_tick);

    // ---------------------------------------------------------------------
    // row of cells; cell 0 holds the oldest entry
    // ---------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_right;
        if (g < CAPACITY - 1) begin : g_mid
            assign w_right = w_entry[g + 1];
        end else begin : g_end
            assign w_right = w_entry[0];   // never selected at the row end
        end
        sdw_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_count (r_count),
            .i_new   (w_new),
            .i_right (w_right),
            .i_head  (w_entry[0]),
            .o_entry (w_entry[g])
        );
    end

    // ---------------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_count    = r_count;
        n_steps    = r_steps;
        n_pend_vld = r_pend_vld;
        n_pend_id  = r_pend_id;
        n_strobe   = 1'b0;
        n_res      = r_res;
        w_ctrl     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_word.mode == MODE_SLEEP) begin
                        n_strobe       = 1'b1;
                        n_res.woken_id = '0;
                        n_res.last     = 1'b1;
                        if (r_count == COUNT_FULL) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            n_res.status = STAT_ACCEPT;
                            w_ctrl.load  = 1'b1;
                            n_count      = r_count + COUNT_ONE;
                        end
                    end else begin
                        if (r_tick != 32'hFFFF_FFFF) begin
                            n_tick = r_tick + 32'd1;
                        end
                        n_steps    = r_count;
                        n_pend_vld = 1'b0;
                        n_state    = (r_count == '0) ? S_FIN : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_ctrl.step = 1'b1;
                w_ctrl.keep = !w_expired;
                if (w_expired) begin
                    n_count = r_count - COUNT_ONE;
                    if (r_pend_vld) begin
                        n_strobe       = 1'b1;
                        n_res.status   = STAT_WOKEN;
                        n_res.woken_id = r_pend_id;
                        n_res.last     = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_id  = w_entry[0].id;
                end
                n_steps = r_steps - COUNT_ONE;
                if (r_steps == COUNT_ONE) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_strobe   = 1'b1;
                n_res.last = 1'b1;
                if (r_pend_vld) begin
                    n_res.status   = STAT_WOKEN;
                    n_res.woken_id = r_pend_id;
                end else begin
                    n_res.status   = STAT_NONE;
                    n_res.woken_id = '0;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tick     <= '0;
            r_count    <= '0;
            r_steps    <= '0;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_count    <= n_count;
            r_steps    <= n_steps;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        r_res     <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_word   = r_res;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("entry count above capacity");

    a_sleep_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_word.mode == MODE_SLEEP)) |=> (o_strobe && o_word.last))
        else $error("sleep word not answered in the next cycle");

    a_empty_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_word.mode == MODE_TICK) && (r_count == '0))
        |=> ##1 (o_strobe && (o_word.status == STAT_NONE) && o_word.last))
        else $error("tick on empty table gave no none result");

    a_scan_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> (r_count <= $past(r_count)))
        else $error("table grew during a sweep");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_steps != '0) && (r_steps <= r_count)))
        else $error("sweep step count out of step with entry count");

endmodule
